@@ rtl/core/gfqe_pkg.sv @@
package gfqe_pkg;

    // Field widths of the command and result channels
    localparam int CMD_W    = 2;
    localparam int ITEM_W   = 12;
    localparam int TEAM_W   = 10;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 11;

    // Default sizing
    localparam int DEF_QUEUE_DEPTH = 1024;
    localparam int DEF_ID_SPACE    = 4096;
    localparam int DEF_TEAM_COUNT  = 1024;

    // Command codes; the spare code behaves as a dequeue
    typedef enum logic [CMD_W-1:0] {
        CMD_ASSIGN  = 2'd0,
        CMD_ENQUEUE = 2'd1,
        CMD_DEQUEUE = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_ASSIGNED = 3'd0,
        ST_ENQUEUED = 3'd1,
        ST_DEQUEUED = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    // Controller -> datapath
    typedef struct packed {
        logic clear;     // one step of the post-reset clearing pass
        logic capture;   // input transfer: latch fields, launch first reads
        logic look;      // resolve team and slot, read team record
        logic update;    // link node, move pointers
        logic link;      // second half of a mid-queue insert
        logic load_out;  // move result into the output register
    } t_dp_ctrl;

    // Datapath -> controller
    typedef struct packed {
        logic clear_done;
        logic look_done;  // assign, full or empty: no update needed
        logic need_link;  // enqueue goes behind a teammate, not at the tail
    } t_dp_stat;

endpackage

@@ rtl/core/gfqe_ctrl.sv @@
module gfqe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  gfqe_pkg::t_dp_stat  i_stat,
    output gfqe_pkg::t_dp_ctrl  o_ctrl
);
    import gfqe_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_LOOK   = 6'b000100,
        S_UPDATE = 6'b001000,
        S_LINK   = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   in_open;
    logic   accept;
    logic   load;

    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        in_open  = (r_state == S_IDLE) || ((r_state == S_EMIT) && out_free);
        accept   = i_in_valid && in_open;
        load     = (r_state == S_EMIT) && out_free;

        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) n_state = S_LOOK;
            end
            S_LOOK: begin
                n_state = i_stat.look_done ? S_EMIT : S_UPDATE;
            end
            S_UPDATE: begin
                n_state = i_stat.need_link ? S_LINK : S_EMIT;
            end
            S_LINK: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (load) n_state = accept ? S_LOOK : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = load || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_ctrl.clear    = (r_state == S_CLEAR);
        o_ctrl.capture  = accept;
        o_ctrl.look     = (r_state == S_LOOK);
        o_ctrl.update   = (r_state == S_UPDATE);
        o_ctrl.link     = (r_state == S_LINK);
        o_ctrl.load_out = load;
    end

    assign o_in_stall  = !in_open;
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/core/gfqe_dp.sv @@
module gfqe_dp #(
    parameter int QUEUE_DEPTH = gfqe_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_SPACE    = gfqe_pkg::DEF_ID_SPACE,
    parameter int TEAM_COUNT  = gfqe_pkg::DEF_TEAM_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gfqe_pkg::t_dp_ctrl            i_ctrl,
    output gfqe_pkg::t_dp_stat            o_stat,
    input  logic [gfqe_pkg::CMD_W-1:0]    i_cmd,
    input  logic [gfqe_pkg::ITEM_W-1:0]   i_item_id,
    input  logic [gfqe_pkg::TEAM_W-1:0]   i_team_id,
    output logic [gfqe_pkg::ITEM_W-1:0]   o_out_item,
    output logic [gfqe_pkg::STATUS_W-1:0] o_status,
    output logic [gfqe_pkg::OCC_W-1:0]    o_occupancy
);
    import gfqe_pkg::*;

    localparam int SW        = $clog2(QUEUE_DEPTH);
    localparam int IW        = $clog2(ID_SPACE);
    localparam int TW        = $clog2(TEAM_COUNT);
    localparam int CNTW      = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_QT    = (QUEUE_DEPTH > TEAM_COUNT) ? QUEUE_DEPTH : TEAM_COUNT;
    localparam int CLEAR_LEN = (ID_SPACE > MAX_QT) ? ID_SPACE : MAX_QT;
    localparam int CLW       = $clog2(CLEAR_LEN);

    // storage
    logic [TEAM_W-1:0] team_table_mem [ID_SPACE];
    logic [ITEM_W-1:0] slot_item_mem  [QUEUE_DEPTH];
    logic [TW-1:0]     slot_team_mem  [QUEUE_DEPTH];
    logic [SW-1:0]     slot_next_mem  [QUEUE_DEPTH];
    logic [SW:0]       team_info_mem  [TEAM_COUNT];   // {present, last slot}
    logic [SW-1:0]     free_ring_mem  [QUEUE_DEPTH];

    // latched command
    logic [CMD_W-1:0]  r_cmd;
    logic [ITEM_W-1:0] r_item;
    logic [TEAM_W-1:0] r_team_in;

    // read data
    logic [TEAM_W-1:0] r_tt_rd;
    logic [ITEM_W-1:0] r_si_rd;
    logic [TW-1:0]     r_st_rd;
    logic [SW-1:0]     r_sn_rd;
    logic [SW-1:0]     r_fr_rd;
    logic [SW:0]       r_ti_rd;

    // work registers
    logic [TW-1:0]     r_team;
    logic [SW-1:0]     r_slot;
    t_status           r_status;

    // queue state
    logic [SW-1:0]     r_head;
    logic [SW-1:0]     r_tail;
    logic [SW-1:0]     r_frd_ptr;
    logic [SW-1:0]     r_fwr_ptr;
    logic [CNTW-1:0]   r_count;
    logic [CLW-1:0]    r_clr_cnt;

    // result register
    logic [ITEM_W-1:0] r_out_item;
    t_status           r_out_status;
    logic [OCC_W-1:0]  r_out_occ;

    logic              is_assign;
    logic              is_enq;
    logic              is_deq;
    logic              q_empty;
    logic              q_full;
    logic              item_ok;
    logic [TEAM_W-1:0] raw_team;
    logic [TW-1:0]     enq_team;
    logic [TW-1:0]     look_team;
    logic              ti_present;
    logic [SW-1:0]     ti_last;
    logic              team_nz;
    logic              link;
    logic              drop_mark;
    logic [IW-1:0]     item_addr;
    logic [SW-1:0]     frd_adv;
    logic [SW-1:0]     fwr_adv;

    logic              tt_we;
    logic [IW-1:0]     tt_wa;
    logic [TEAM_W-1:0] tt_wd;
    logic              ti_we;
    logic [TW-1:0]     ti_wa;
    logic [SW:0]       ti_wd;
    logic              fr_we;
    logic [SW-1:0]     fr_wa;
    logic [SW-1:0]     fr_wd;
    logic              sn_we;
    logic [SW-1:0]     sn_wa;
    logic [SW-1:0]     sn_wd;
    logic              sn_re;
    logic [SW-1:0]     sn_ra;
    logic              slot_we;

    always_comb begin
        is_assign = (r_cmd == CMD_ASSIGN);
        is_enq    = (r_cmd == CMD_ENQUEUE);
        is_deq    = !is_assign && !is_enq;
        q_empty   = (r_count == '0);
        q_full    = (r_count == CNTW'(QUEUE_DEPTH));
        item_ok   = (32'(r_item) < 32'(ID_SPACE));
        raw_team  = item_ok ? r_tt_rd : '0;
        enq_team  = (32'(raw_team) < 32'(TEAM_COUNT)) ? TW'(raw_team) : '0;
        look_team = is_enq ? enq_team : r_st_rd;

        ti_present = r_ti_rd[SW];
        ti_last    = r_ti_rd[SW-1:0];
        team_nz    = (r_team != '0);
        // teammate still queued and not already at the tail: insert after it
        link       = is_enq && !q_empty && team_nz && ti_present && (ti_last != r_tail);
        // dequeued node was the team's last queued member
        drop_mark  = is_deq && team_nz && ti_present && (ti_last == r_slot);

        item_addr = IW'(i_item_id);
        frd_adv   = (r_frd_ptr == SW'(QUEUE_DEPTH - 1)) ? '0 : r_frd_ptr + SW'(1);
        fwr_adv   = (r_fwr_ptr == SW'(QUEUE_DEPTH - 1)) ? '0 : r_fwr_ptr + SW'(1);
    end

    // write and read port selection
    always_comb begin
        tt_we = (i_ctrl.clear && (32'(r_clr_cnt) < 32'(ID_SPACE)))
              || (i_ctrl.look && is_assign && item_ok);
        tt_wa = i_ctrl.clear ? r_clr_cnt[IW-1:0] : IW'(r_item);
        tt_wd = i_ctrl.clear ? '0 : r_team_in;

        ti_we = (i_ctrl.clear && (32'(r_clr_cnt) < 32'(TEAM_COUNT)))
              || (i_ctrl.update && ((is_enq && team_nz) || drop_mark));
        ti_wa = i_ctrl.clear ? r_clr_cnt[TW-1:0] : r_team;
        ti_wd = i_ctrl.clear ? '0 : (is_enq ? {1'b1, r_slot} : {1'b0, ti_last});

        fr_we = (i_ctrl.clear && (32'(r_clr_cnt) < 32'(QUEUE_DEPTH)))
              || (i_ctrl.update && is_deq);
        fr_wa = i_ctrl.clear ? r_clr_cnt[SW-1:0] : r_fwr_ptr;
        fr_wd = i_ctrl.clear ? r_clr_cnt[SW-1:0] : r_slot;

        slot_we = i_ctrl.update && is_enq;

        sn_we = (i_ctrl.update && is_enq && !q_empty) || i_ctrl.link;
        sn_wa = i_ctrl.link ? r_slot : (link ? ti_last : r_tail);
        sn_wd = i_ctrl.link ? r_sn_rd : r_slot;
        sn_re = i_ctrl.capture || (i_ctrl.update && link);
        sn_ra = i_ctrl.capture ? r_head : ti_last;
    end

    always_ff @(posedge i_clk) begin
        if (tt_we) team_table_mem[tt_wa] <= tt_wd;
        if (i_ctrl.capture) r_tt_rd <= team_table_mem[item_addr];
    end

    always_ff @(posedge i_clk) begin
        if (ti_we) team_info_mem[ti_wa] <= ti_wd;
        if (i_ctrl.look) r_ti_rd <= team_info_mem[look_team];
    end

    always_ff @(posedge i_clk) begin
        if (fr_we) free_ring_mem[fr_wa] <= fr_wd;
        if (i_ctrl.capture) r_fr_rd <= free_ring_mem[r_frd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) slot_item_mem[r_slot] <= r_item;
        if (i_ctrl.capture) r_si_rd <= slot_item_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) slot_team_mem[r_slot] <= r_team;
        if (i_ctrl.capture) r_st_rd <= slot_team_mem[r_head];
    end

    // read-first: the insert reads the old successor while pointing it at the new node
    always_ff @(posedge i_clk) begin
        if (sn_we) slot_next_mem[sn_wa] <= sn_wd;
        if (sn_re) r_sn_rd <= slot_next_mem[sn_ra];
    end

    // command latch and per-command work registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd     <= i_cmd;
            r_item    <= i_item_id;
            r_team_in <= i_team_id;
        end
        if (i_ctrl.look) begin
            r_team <= look_team;
            r_slot <= is_enq ? r_fr_rd : r_head;
            priority if (is_assign) begin
                r_status <= ST_ASSIGNED;
            end else if (is_enq) begin
                r_status <= q_full ? ST_FULL : ST_ENQUEUED;
            end else begin
                r_status <= q_empty ? ST_EMPTY : ST_DEQUEUED;
            end
        end
        if (i_ctrl.load_out) begin
            r_out_item   <= (r_status == ST_DEQUEUED) ? r_si_rd : '0;
            r_out_status <= r_status;
            r_out_occ    <= OCC_W'(r_count);
        end
    end

    // list pointers, free ring pointers, count, clearing counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_frd_ptr <= '0;
            r_fwr_ptr <= '0;
            r_count   <= '0;
            r_clr_cnt <= '0;
        end else begin
            if (i_ctrl.clear) r_clr_cnt <= r_clr_cnt + CLW'(1);
            if (i_ctrl.update && is_enq) begin
                r_frd_ptr <= frd_adv;
                r_count   <= r_count + CNTW'(1);
                if (q_empty) begin
                    r_head <= r_slot;
                    r_tail <= r_slot;
                end else if (!link) begin
                    r_tail <= r_slot;
                end
            end
            if (i_ctrl.update && is_deq) begin
                r_head    <= r_sn_rd;
                r_fwr_ptr <= fwr_adv;
                r_count   <= r_count - CNTW'(1);
            end
        end
    end

    always_comb begin
        o_stat.clear_done = (r_clr_cnt == CLW'(CLEAR_LEN - 1));
        o_stat.look_done  = is_assign || (is_enq && q_full) || (is_deq && q_empty);
        o_stat.need_link  = link;
    end

    assign o_out_item  = r_out_item;
    assign o_status    = r_out_status;
    assign o_occupancy = r_out_occ;

endmodule

@@ rtl/core/grouped_fifo_queue_engine.sv @@
// Team queue: a linked-list FIFO whose items are grouped into teams. Command 0
// records an item's team (0 = no team) in a membership table; command 1 enqueues
// an item directly behind the last still-queued member of its team, or at the
// tail when there is none; commands 2 and 3 dequeue the head and return it in
// the same result. Every command produces exactly one result transfer carrying
// the removed item (zero unless dequeued), a status code and the occupancy after
// the command. An enqueue into a full queue is dropped with status "full"; a
// dequeue of an empty queue returns status "empty". A queued item keeps the team
// it had when it was enqueued. Assign, full and empty go from look straight to
// emit; an enqueue at the tail and a dequeue add an update step, and an enqueue
// that slots in behind a teammate adds a link step as well. The steps follow the
// chain of dependent registered RAM reads: membership table, then the team's
// last-slot record, then the successor pointer. After reset the block sweeps its
// membership table, team records and free-slot ring and holds o_in_stall high
// meanwhile. A new command is taken while the previous result still waits in
// the output register.
module grouped_fifo_queue_engine #(
    parameter int QUEUE_DEPTH = gfqe_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_SPACE    = gfqe_pkg::DEF_ID_SPACE,
    parameter int TEAM_COUNT  = gfqe_pkg::DEF_TEAM_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [gfqe_pkg::CMD_W-1:0]    i_cmd,
    input  logic [gfqe_pkg::ITEM_W-1:0]   i_item_id,
    input  logic [gfqe_pkg::TEAM_W-1:0]   i_team_id,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [gfqe_pkg::ITEM_W-1:0]   o_out_item,
    output logic [gfqe_pkg::STATUS_W-1:0] o_status,
    output logic [gfqe_pkg::OCC_W-1:0]    o_occupancy
);
    import gfqe_pkg::*;

    // Controller sequences clear / look / update / link / emit; the datapath
    // owns all RAMs and the list pointers.
    t_dp_ctrl dp_ctrl;
    t_dp_stat dp_stat;

    gfqe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_ctrl      (dp_ctrl)
    );

    gfqe_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_SPACE    (ID_SPACE),
        .TEAM_COUNT  (TEAM_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (dp_ctrl),
        .o_stat      (dp_stat),
        .i_cmd       (i_cmd),
        .i_item_id   (i_item_id),
        .i_team_id   (i_team_id),
        .o_out_item  (o_out_item),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

endmodule

@@ rtl/core/gfqe_checker.sv @@
module gfqe_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [gfqe_pkg::ITEM_W-1:0]   o_out_item,
    input logic [gfqe_pkg::STATUS_W-1:0] o_status,
    input logic [gfqe_pkg::OCC_W-1:0]    o_occupancy
);
    import gfqe_pkg::*;

    // clearing pass blocks commands right after reset
    a_stall_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_in_stall)
        else $error("command accepted during clearing pass");

    a_item_only_on_dequeue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_DEQUEUED)) |-> (o_out_item == '0))
        else $error("nonzero item on a non-dequeue result");

    a_empty_means_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_EMPTY)) |-> (o_occupancy == '0))
        else $error("empty status with nonzero occupancy");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            ($stable(o_out_item) && $stable(o_status) && $stable(o_occupancy)))
        else $error("result changed while stalled");

endmodule

bind grouped_fifo_queue_engine gfqe_checker u_gfqe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item),
    .o_status    (o_status),
    .o_occupancy (o_occupancy)
);

@@ tb/grouped_fifo_queue_engine_tb.sv @@
`timescale 1ns / 100ps

module grouped_fifo_queue_engine_tb;
    import gfqe_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 4;
    localparam int QDEPTH       = DEF_QUEUE_DEPTH;
    localparam int IDS          = DEF_ID_SPACE;
    localparam int TEAMS        = DEF_TEAM_COUNT;
    localparam int SLOT_W       = $clog2(QDEPTH);
    localparam int RAND_ITEMS   = 400;
    // Covers the post-reset sweep and the long sink hold-off several times
    // over; counts only cycles with no transfer at all.
    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 16;

    // Spare command code, behaves as a dequeue
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [ITEM_W-1:0]   item;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occ;
    } t_result;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [ITEM_W-1:0] item;
        logic [TEAM_W-1:0] team;
        bit                typed;
        t_result           res;
    } t_stim_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic [CMD_W-1:0]    i_cmd       = CMD_ASSIGN;
    logic [ITEM_W-1:0]   i_item_id   = '0;
    logic [TEAM_W-1:0]   i_team_id   = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [ITEM_W-1:0]   o_out_item;
    logic [STATUS_W-1:0] o_status;
    logic [OCC_W-1:0]    o_occupancy;

    grouped_fifo_queue_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_item_id   (i_item_id),
        .i_team_id   (i_team_id),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Team queue predictor: own copy of the linked-list state.
    // With default sizing every item id and team id is in range, so the
    // out-of-range cases collapse and slot/ring pointers wrap on width.
    // ------------------------------------------------------------------
    logic [TEAM_W-1:0] team_of_item   [IDS];
    logic [ITEM_W-1:0] node_item      [QDEPTH];
    logic [SLOT_W-1:0] node_next      [QDEPTH];
    logic [TEAM_W-1:0] node_team      [QDEPTH];
    logic [SLOT_W-1:0] team_last_node [TEAMS];
    bit                team_live      [TEAMS];
    logic [SLOT_W-1:0] free_slots     [QDEPTH];
    logic [SLOT_W-1:0] free_rd, free_wr, head_node, tail_node;
    logic [OCC_W-1:0]  queued;

    function automatic t_result step_team_queue(input logic [CMD_W-1:0] c,
                                                input logic [ITEM_W-1:0] it,
                                                input logic [TEAM_W-1:0] tm);
        t_result           r;
        logic [TEAM_W-1:0] t;
        logic [SLOT_W-1:0] s;
        logic [SLOT_W-1:0] l;
        r = '0;
        case (c)
            CMD_ASSIGN: begin
                team_of_item[it] = tm;
                r.status = ST_ASSIGNED;
            end
            CMD_ENQUEUE: begin
                if (queued >= QDEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    t = team_of_item[it];
                    s = free_slots[free_rd];
                    free_rd = free_rd + 1'b1;
                    node_item[s] = it;
                    node_team[s] = t;
                    if (queued == 0) begin
                        head_node = s;
                        tail_node = s;
                    end else if (t != 0 && team_live[t] && team_last_node[t] != tail_node) begin
                        // slot in right behind the last queued teammate
                        l = team_last_node[t];
                        node_next[s] = node_next[l];
                        node_next[l] = s;
                    end else begin
                        node_next[tail_node] = s;
                        tail_node = s;
                    end
                    if (t != 0) begin
                        team_last_node[t] = s;
                        team_live[t] = 1'b1;
                    end
                    queued = queued + 1'b1;
                    r.status = ST_ENQUEUED;
                end
            end
            default: begin
                if (queued == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    s = head_node;
                    t = node_team[s];
                    r.item = node_item[s];
                    // team is gone from the queue once its last member leaves
                    if (t != 0 && team_live[t] && team_last_node[t] == s)
                        team_live[t] = 1'b0;
                    head_node = node_next[s];
                    free_slots[free_wr] = s;
                    free_wr = free_wr + 1'b1;
                    queued = queued - 1'b1;
                    r.status = ST_DEQUEUED;
                end
            end
        endcase
        r.occ = queued;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Expected results, oldest first, and the result-side checker
    // ------------------------------------------------------------------
    t_result expected_results[$];
    t_result head_exp;
    bit      failed = 1'b0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing pending: item=%0d status=%0d occ=%0d",
                         $time, o_out_item, o_status, o_occupancy);
                failed = 1'b1;
            end else begin
                head_exp = expected_results.pop_front();
                if (o_out_item !== head_exp.item) begin
                    $display("%0t: out_item expected %0d actual %0d",
                             $time, head_exp.item, o_out_item);
                    failed = 1'b1;
                end
                if (o_status !== head_exp.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, head_exp.status, o_status);
                    failed = 1'b1;
                end
                if (o_occupancy !== head_exp.occ) begin
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, head_exp.occ, o_occupancy);
                    failed = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result-side stall: random idling, or a long hold-off when the
    // stimulus asks for one (hold_asks bumps, this process counts it out)
    // ------------------------------------------------------------------
    bit sink_idle_en = 1'b1;
    int hold_asks    = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= sink_idle_en && ($urandom_range(99) < 20);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too many cycles in a row with no transfer on either side
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, %0d results pending",
                     $time, expected_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Command-side driver
    // ------------------------------------------------------------------
    bit src_idle_en = 1'b1;
    t_stim_row directed_rows[$];

    task automatic add_row(input logic [CMD_W-1:0] c, input logic [ITEM_W-1:0] it,
                           input logic [TEAM_W-1:0] tm, input bit typed,
                           input logic [ITEM_W-1:0] e_item,
                           input logic [STATUS_W-1:0] e_status,
                           input logic [OCC_W-1:0] e_occ);
        t_stim_row row;
        row.cmd        = c;
        row.item       = it;
        row.team       = tm;
        row.typed      = typed;
        row.res.item   = e_item;
        row.res.status = e_status;
        row.res.occ    = e_occ;
        directed_rows.push_back(row);
    endtask

    // Offers one command and returns at the edge where it transfers, with
    // valid left high so a back-to-back command needs no extra assignment.
    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [ITEM_W-1:0] it,
                            input logic [TEAM_W-1:0] tm, input bit typed,
                            input t_result typed_res);
        t_result model_res;
        while (src_idle_en && $urandom_range(99) < 20) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= c;
        i_item_id  <= it;
        i_team_id  <= tm;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        model_res = step_team_queue(c, it, tm);
        expected_results.push_back(typed ? typed_res : model_res);
    endtask

    // Sender pause until every pending result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic send_random(input int n);
        int                r;
        bit                enq_heavy;
        logic [CMD_W-1:0]  c;
        logic [ITEM_W-1:0] it;
        logic [TEAM_W-1:0] tm;
        for (int k = 0; k < n; k++) begin
            // long stretch with no idling on either side
            src_idle_en  = !(k >= 150 && k < 300);
            sink_idle_en = src_idle_en;
            if (k == 320)
                wait_drained();
            // alternate between growing and shrinking the queue
            enq_heavy = ((k / 100) % 2) == 0;
            r = $urandom_range(99);
            if (r < 20)
                c = CMD_ASSIGN;
            else if (r < (enq_heavy ? 62 : 42))
                c = CMD_ENQUEUE;
            else
                c = ($urandom_range(3) == 0) ? CMD_SPARE : CMD_DEQUEUE;
            // small id pool so teams collide; occasional full-range ids
            it = ($urandom_range(9) == 0) ? ITEM_W'($urandom_range(IDS - 1))
                                           : ITEM_W'($urandom_range(47));
            r = $urandom_range(99);
            if (r < 10)
                tm = TEAM_W'($urandom_range(TEAMS - 1));
            else if (r < 25)
                tm = '0;
            else
                tm = TEAM_W'($urandom_range(7, 1));
            send_cmd(c, it, tm, 1'b0, '0);
        end
    endtask

    initial begin
        // predictor reset state
        foreach (team_of_item[k]) team_of_item[k] = '0;
        foreach (node_item[k]) begin
            node_item[k]  = '0;
            node_next[k]  = '0;
            node_team[k]  = '0;
            free_slots[k] = SLOT_W'(k);
        end
        foreach (team_live[k]) begin
            team_live[k]      = 1'b0;
            team_last_node[k] = '0;
        end
        free_rd   = '0;
        free_wr   = '0;
        head_node = '0;
        tail_node = '0;
        queued    = '0;

        // Directed table; typed results only where obvious
        add_row(CMD_DEQUEUE, 12'd0,    10'd0,    1, 12'd0, ST_EMPTY,    11'd0); // empty
        add_row(CMD_SPARE,   12'd4095, 10'd1023, 1, 12'd0, ST_EMPTY,    11'd0); // spare code
        add_row(CMD_ASSIGN,  12'd4095, 10'd5,    1, 12'd0, ST_ASSIGNED, 11'd0);
        add_row(CMD_ASSIGN,  12'd0,    10'd1023, 1, 12'd0, ST_ASSIGNED, 11'd0);
        add_row(CMD_ASSIGN,  12'd7,    10'd5,    1, 12'd0, ST_ASSIGNED, 11'd0);
        add_row(CMD_ENQUEUE, 12'd4095, 10'd0,    1, 12'd0, ST_ENQUEUED, 11'd1);
        add_row(CMD_ENQUEUE, 12'd100,  10'd1023, 1, 12'd0, ST_ENQUEUED, 11'd2); // no team
        add_row(CMD_ENQUEUE, 12'd0,    10'd0,    1, 12'd0, ST_ENQUEUED, 11'd3);
        add_row(CMD_ENQUEUE, 12'd7,    10'd0,    0, 12'd0, ST_ENQUEUED, 11'd0); // behind 4095
        add_row(CMD_ASSIGN,  12'd4095, 10'd0,    1, 12'd0, ST_ASSIGNED, 11'd4); // reassign queued
        add_row(CMD_ASSIGN,  12'd7,    10'd1023, 1, 12'd0, ST_ASSIGNED, 11'd4);
        add_row(CMD_ENQUEUE, 12'd2048, 10'd0,    0, 12'd0, ST_ENQUEUED, 11'd0);
        add_row(CMD_DEQUEUE, 12'd0,    10'd0,    0, 12'd0, ST_DEQUEUED, 11'd0);
        add_row(CMD_DEQUEUE, 12'd0,    10'd0,    0, 12'd0, ST_DEQUEUED, 11'd0);
        add_row(CMD_SPARE,   12'd0,    10'd0,    0, 12'd0, ST_DEQUEUED, 11'd0);
        add_row(CMD_DEQUEUE, 12'd0,    10'd0,    0, 12'd0, ST_DEQUEUED, 11'd0);
        add_row(CMD_DEQUEUE, 12'd0,    10'd0,    0, 12'd0, ST_DEQUEUED, 11'd0);
        add_row(CMD_DEQUEUE, 12'd0,    10'd0,    1, 12'd0, ST_EMPTY,    11'd0);
        add_row(CMD_ENQUEUE, 12'd0,    10'd0,    0, 12'd0, ST_ENQUEUED, 11'd0);
        add_row(CMD_ENQUEUE, 12'd7,    10'd0,    0, 12'd0, ST_ENQUEUED, 11'd0);
        add_row(CMD_ASSIGN,  12'd2730, 10'd682,  0, 12'd0, ST_ASSIGNED, 11'd0);
        add_row(CMD_ASSIGN,  12'd1365, 10'd341,  0, 12'd0, ST_ASSIGNED, 11'd0);
        add_row(CMD_ENQUEUE, 12'd1365, 10'd0,    0, 12'd0, ST_ENQUEUED, 11'd0);
        add_row(CMD_ENQUEUE, 12'd2730, 10'd0,    0, 12'd0, ST_ENQUEUED, 11'd0);
        add_row(CMD_ENQUEUE, 12'd0,    10'd0,    0, 12'd0, ST_ENQUEUED, 11'd0); // team mid-queue

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            send_cmd(directed_rows[k].cmd, directed_rows[k].item, directed_rows[k].team,
                     directed_rows[k].typed, directed_rows[k].res);

        // Full-queue sweep: small teams over a small id pool, fill past
        // capacity (drops), then drain half of it. The sink holds off at
        // the start so the output side backs up into the command side.
        wait_drained();
        for (int k = 0; k < 64; k++)
            send_cmd(CMD_ASSIGN, ITEM_W'(k), TEAM_W'($urandom_range(15)), 1'b0, '0);
        hold_asks = hold_asks + 1;
        for (int k = 0; k < QDEPTH + 3; k++)
            send_cmd(CMD_ENQUEUE, ITEM_W'($urandom_range(63)),
                     TEAM_W'($urandom_range(TEAMS - 1)), 1'b0, '0);
        for (int k = 0; k < QDEPTH / 2; k++)
            send_cmd(($urandom_range(3) == 0) ? CMD_SPARE : CMD_DEQUEUE,
                     ITEM_W'($urandom_range(IDS - 1)), TEAM_W'($urandom_range(TEAMS - 1)),
                     1'b0, '0);

        // Random traffic, starting under a second long sink hold-off
        hold_asks = hold_asks + 1;
        send_random(RAND_ITEMS);

        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/gfqe_pkg.sv
rtl/core/gfqe_ctrl.sv
rtl/core/gfqe_dp.sv
rtl/core/grouped_fifo_queue_engine.sv
rtl/core/gfqe_checker.sv
tb/grouped_fifo_queue_engine_tb.sv
